@@ rtl/fmpf_pkg.sv @@
// Package: types, constants and helpers of the first-match packet filter.
`default_nettype none
package fmpf_pkg;
  localparam int RULE_COUNT_DEF = 32;
  localparam int PF_W = 44;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  localparam logic [1:0] SEL_SRC = 2'd0;
  localparam logic [1:0] SEL_DST = 2'd1;
  localparam logic [1:0] SEL_PF  = 2'd2;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_PERMIT = 2'd1;
  localparam logic [1:0] ACT_DENY   = 2'd2;

  localparam logic [2:0] CLS_ANY  = 3'd0;
  localparam logic [2:0] CLS_ICMP = 3'd1;
  localparam logic [2:0] CLS_UDP  = 3'd2;
  localparam logic [2:0] CLS_TCP  = 3'd3;
  localparam logic [2:0] CLS_IGMP = 3'd4;

  localparam logic [1:0] OP_EQ = 2'd1;
  localparam logic [1:0] OP_GT = 2'd2;
  localparam logic [1:0] OP_LT = 2'd3;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_IGMP = 8'd2;
  localparam logic [7:0] PROTO_IPIP = 8'd4;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;
  localparam logic [7:0] TOS_FAST   = 8'h10;

  // Packet word as carried down the pipeline.
  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [2:0]  cls;
    logic        known;
    logic        frag;
    logic [15:0] sport;
    logic [15:0] dport;
    logic        ack;
    logic        syn;
    logic        finrst;
    logic        fast;
  } pkt_t;

  // Running verdict: done once a rule (or an early exit) decides.
  typedef struct packed {
    logic       done;
    logic [1:0] act;
  } verd_t;

  function automatic logic is_fast_port(input logic [15:0] p);
    logic [15:0] t;
    case (p[4:0])
      5'd0:  t = 16'd544;
      5'd1:  t = 16'd513;
      5'd2:  t = 16'd514;
      5'd16: t = 16'd80;
      5'd17: t = 16'd81;
      5'd21: t = 16'd21;
      5'd22: t = 16'd22;
      5'd23: t = 16'd23;
      5'd31: t = 16'd543;
      default: t = 16'd0;
    endcase
    return t == p;
  endfunction

  function automatic logic port_test(input logic [1:0] op, input logic [15:0] pkt,
                                     input logic [15:0] rule);
    logic r;
    case (op)
      OP_EQ:   r = (pkt == rule);
      OP_GT:   r = (pkt > rule);
      OP_LT:   r = (pkt < rule);
      default: r = 1'b1;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

@@ rtl/fmpf_rule_stage.sv @@
// One pipeline stage: tests a group of rules against the packet word.
`default_nettype none
module fmpf_rule_stage
  import fmpf_pkg::*;
#(
  parameter int NR = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic frag_permit,
  input  wire logic [NR-1:0][63:0]     src_w,
  input  wire logic [NR-1:0][63:0]     dst_w,
  input  wire logic [NR-1:0][PF_W-1:0] pf_w,
  input  wire logic  vld_i,
  input  wire pkt_t  pkt_i,
  input  wire verd_t verd_i,
  output logic  vld_o,
  output pkt_t  pkt_o,
  output verd_t verd_o
);
  logic  vld_r;
  pkt_t  pkt_r;
  verd_t verd_r, verd_nxt;

  always_comb begin
    logic [1:0] act;
    logic       am;
    logic       pm;
    verd_nxt = verd_i;
    for (int k = 0; k < NR; k++) begin
      act = pf_w[k][1:0];
      am = ((pkt_i.src & src_w[k][63:32]) == (src_w[k][31:0] & src_w[k][63:32])) &&
           ((pkt_i.dst & dst_w[k][63:32]) == (dst_w[k][31:0] & dst_w[k][63:32]));
      pm = (pkt_i.cls == pf_w[k][4:2]) &&
           port_test(pf_w[k][6:5], pkt_i.sport, pf_w[k][22:7]) &&
           port_test(pf_w[k][24:23], pkt_i.dport, pf_w[k][40:25]) &&
           (!pf_w[k][41] || pkt_i.ack) && (!pf_w[k][42] || pkt_i.syn) &&
           (!pf_w[k][43] || pkt_i.finrst);
      if (!verd_nxt.done && act != ACT_NONE) begin
        if (frag_permit && pkt_i.frag) verd_nxt = '{1'b1, ACT_PERMIT};
        else if (am) begin
          if (pf_w[k][4:2] == CLS_ANY) verd_nxt = '{1'b1, act};
          else if (!pkt_i.known)       verd_nxt = '{1'b1, ACT_DENY};
          else if (pm)                 verd_nxt = '{1'b1, act};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= 1'b0;
    else        vld_r <= vld_i;
    pkt_r  <= pkt_i;
    verd_r <= verd_nxt;
  end

  assign vld_o  = vld_r;
  assign pkt_o  = pkt_r;
  assign verd_o = verd_r;
endmodule
`default_nettype wire

@@ rtl/first_match_ip_packet_filter_unit.sv @@
// Top level of the first-match IP packet filter.
// A check word passes the classify register (stage 0), NS = ceil(RULE_COUNT/4) rule
// stages and the output register before its result appears on out_strobe.
// Throughput: one word per cycle; busy rises only for a load word while a check is still
// reading the rule table. The receiver cannot stall.
// Reset (synchronous, rst_n low) clears the rule table to all zero, frag_permit
// and all pipeline valid bits.
`default_nettype none
module first_match_ip_packet_filter_unit
  import fmpf_pkg::*;
#(
  parameter int RULE_COUNT = RULE_COUNT_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_command,
  input  wire logic [4:0]  in_rule_index,
  input  wire logic [1:0]  in_word_select,
  input  wire logic [63:0] in_word_value,
  input  wire logic [31:0] in_src_addr,
  input  wire logic [31:0] in_dst_addr,
  input  wire logic [7:0]  in_ip_proto,
  input  wire logic [7:0]  in_type_of_service,
  input  wire logic [12:0] in_frag_offset,
  input  wire logic [15:0] in_first_port,
  input  wire logic [15:0] in_second_port,
  input  wire logic [5:0]  in_tcp_flag_bits,
  output logic             out_strobe,
  output logic             out_denied,
  output logic             out_fast_priority
);
  localparam int RPS = 4;                           // rules per stage
  localparam int NS  = (RULE_COUNT + RPS - 1) / RPS;
  localparam int NT  = NS * RPS;                    // padded table size

  // Rule table in flops, reset to zero; padding slots stay action none.
  logic [NT-1:0][63:0]     src_r;
  logic [NT-1:0][63:0]     dst_r;
  logic [NT-1:0][PF_W-1:0] pf_r;
  logic                    frag_permit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= '0;
      dst_r <= '0;
      pf_r  <= '0;
      frag_permit_r <= 1'b0;
    end else begin
      if (cfg_we) frag_permit_r <= cfg_wdata;
      // Loads to slots past RULE_COUNT, or word select 3, are dropped.
      if (start && !busy && in_command == CMD_LOAD && 32'(in_rule_index) < RULE_COUNT) begin
        for (int i = 0; i < RULE_COUNT; i++) begin
          if (32'(in_rule_index) == i) begin
            case (in_word_select)
              SEL_SRC: src_r[i] <= in_word_value;
              SEL_DST: dst_r[i] <= in_word_value;
              SEL_PF:  pf_r[i]  <= in_word_value[PF_W-1:0];
              default: ;
            endcase
          end
        end
      end
    end
  end

  // Stage 0: classify header and work out the priority candidate.
  logic  v0_r;
  pkt_t  p0_r, p0_nxt;
  verd_t d0_r, d0_nxt;

  always_comb begin
    p0_nxt = '0;
    p0_nxt.src = in_src_addr;
    p0_nxt.dst = in_dst_addr;
    p0_nxt.known = 1'b1;
    p0_nxt.ack = 1'b1;
    p0_nxt.syn = 1'b1;
    p0_nxt.finrst = 1'b1;
    p0_nxt.frag = (in_frag_offset != 13'd0);
    if (in_ip_proto == PROTO_ICMP) begin
      p0_nxt.cls = CLS_ICMP;
      p0_nxt.sport = in_first_port;
    end else if (in_ip_proto == PROTO_IGMP) begin
      p0_nxt.cls = CLS_IGMP;
    end else if (in_ip_proto == PROTO_UDP || in_ip_proto == PROTO_IPIP) begin
      p0_nxt.cls = CLS_UDP;
      p0_nxt.sport = in_first_port;
      p0_nxt.dport = in_second_port;
    end else if (in_ip_proto == PROTO_TCP) begin
      p0_nxt.cls = CLS_TCP;
      p0_nxt.sport = in_first_port;
      p0_nxt.dport = in_second_port;
      p0_nxt.ack = in_tcp_flag_bits[4];
      p0_nxt.syn = in_tcp_flag_bits[1];
      p0_nxt.finrst = in_tcp_flag_bits[0] | in_tcp_flag_bits[2];
    end else begin
      p0_nxt.known = 1'b0;
    end
    p0_nxt.fast = (in_ip_proto == PROTO_TCP) &&
                  ((in_type_of_service == TOS_FAST) ||
                   (!p0_nxt.frag && (is_fast_port(in_first_port) ||
                                     is_fast_port(in_second_port))));
    // Rule 0 with action none counts as an empty table: permitted outright.
    d0_nxt = '0;
    if (pf_r[0][1:0] == ACT_NONE) d0_nxt = '{1'b1, ACT_PERMIT};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else        v0_r <= start && !busy && in_command == CMD_CHECK;
    p0_r <= p0_nxt;
    d0_r <= d0_nxt;
  end

  // Rule stages carry the first match forward.
  logic  [NS:0] v_s;
  pkt_t  [NS:0] p_s;
  verd_t [NS:0] d_s;
  assign v_s[0] = v0_r;
  assign p_s[0] = p0_r;
  assign d_s[0] = d0_r;

  // A load waits while any check still has rule stages to pass, so each
  // check sees the table as it stood when it was accepted.
  assign busy = (in_command == CMD_LOAD) && (|v_s[NS-1:0]);

  for (genvar g = 0; g < NS; g++) begin : g_stage
    fmpf_rule_stage #(.NR(RPS)) u_stage (
      .clk, .rst_n,
      .frag_permit (frag_permit_r),
      .src_w  (src_r[g*RPS +: RPS]),
      .dst_w  (dst_r[g*RPS +: RPS]),
      .pf_w   (pf_r[g*RPS +: RPS]),
      .vld_i  (v_s[g]),  .pkt_i (p_s[g]),  .verd_i (d_s[g]),
      .vld_o  (v_s[g+1]), .pkt_o (p_s[g+1]), .verd_o (d_s[g+1])
    );
  end

  // Output register; no match at all denies. Action bit 1 marks denial.
  logic den_w;
  logic strobe_r, denied_r, fast_r;
  assign den_w = d_s[NS].done ? d_s[NS].act[1] : 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) strobe_r <= 1'b0;
    else        strobe_r <= v_s[NS];
    denied_r <= den_w;
    fast_r   <= !den_w && p_s[NS].fast;
  end

  assign out_strobe        = strobe_r;
  assign out_denied        = denied_r;
  assign out_fast_priority = fast_r;
endmodule
`default_nettype wire
